[src/bdr_pkg.sv]
// shared types and constants for the debounced button with auto-repeat
// no dependencies
package bdr_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CYCLE_W = 16;
    localparam int unsigned RAPID_W = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = TIME_W'(50);
    localparam logic [CYCLE_W-1:0] CYCLE_MAX = '1;
    localparam logic [RAPID_W-1:0] RAPID_MAX = '1;

    // button state reported with each item
    typedef enum logic [CODE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_DELAY   = 3'd1,
        ST_PUSH    = 3'd2,
        ST_HOLD    = 3'd3,
        ST_RELEASE = 3'd4
    } t_state_code;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_INVERT      = 3'd1,
        CFG_LOCAL       = 3'd2,
        CFG_ACCEL_EN    = 3'd3,
        CFG_DEBOUNCE    = 3'd4,
        CFG_REPEAT      = 3'd5,
        CFG_ACCEL_STEP  = 3'd6,
        CFG_ACCEL_FLOOR = 3'd7
    } t_cfg_idx;

endpackage

[src/button_debounce_repeat_fsm.sv]
// debounced push button with auto-repeat, rapid-press detection and acceleration
// depends on bdr_pkg
//
// Each input item is one poll of the button: a millisecond timestamp and the
// raw pin level. For every poll the block returns exactly one item with the
// button state (idle, delay, push, hold, release), a rapid-press flag and the
// rapid-press and repeat counts. A poll is captured in an input register,
// evaluated against the button state in combinational logic (two 32x16
// multiplies in parallel, then adds and compares) and written into the output
// register, from which its report is offered. One poll per clock is sustained
// while the receiver accepts reports. The output register decouples the two
// sides: a poll is still taken into an empty input register while a result
// waits downstream. Configuration is written through a separate port, always
// ready, and should only change while no poll is in flight. While disabled, polls
// change nothing and the last reported state is repeated. All time sums wrap
// modulo 2^32.
module button_debounce_repeat_fsm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // poll input; tdata: [31:0] now_ms, [32] pin_level, [39:33] zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bdr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // result output; tdata: [2:0] state_code, [3] rapid, [11:4] rapid_presses,
    // [27:12] repeat_count, [31:28] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bdr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bdr_pkg::TIME_W-1:0]           i_cfg_data
);
    import bdr_pkg::*;

    // configuration registers
    logic              r_enable, r_invert, r_local, r_accel_en;
    logic [TIME_W-1:0] r_debounce, r_repeat, r_step, r_floor;

    // button state
    logic               r_pressed;
    logic [TIME_W-1:0]  r_push_t, r_release_t, r_hold_t, r_offset;
    logic [CYCLE_W-1:0] r_cycle;
    logic [RAPID_W-1:0] r_rapid_cnt;
    t_state_code        r_last_state;
    logic               r_last_rapid;

    // input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_now;
    logic              r_in_level;

    // output register
    logic               r_out_valid;
    t_state_code        r_out_state;
    logic               r_out_rapid;
    logic [RAPID_W-1:0] r_out_rapid_cnt;
    logic [CYCLE_W-1:0] r_out_cycle;

    // next state
    logic               n_pressed;
    logic [TIME_W-1:0]  n_push_t, n_release_t, n_hold_t, n_offset;
    logic [CYCLE_W-1:0] n_cycle;
    logic [RAPID_W-1:0] n_rapid_cnt;
    t_state_code        n_last_state;
    logic               n_last_rapid;

    logic advance;

    // working values of the poll
    logic [TIME_W-1:0]         w_base, w_target, w_lim, w_inc;
    logic [TIME_W+CYCLE_W-1:0] w_rep_prod, w_step_prod;
    logic [CYCLE_W-1:0]        w_n1, w_cycle_inc;
    logic [RAPID_W-1:0]        w_rapid_inc;
    logic                      w_active, w_mash, w_fire;

    // handshakes
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_cycle, r_out_rapid_cnt, r_out_rapid,
                            r_out_state};

    // poll evaluation
    always_comb begin
        w_base      = (r_push_t > r_release_t) ? r_push_t : r_release_t;
        w_active    = r_in_level ^ r_invert;
        w_mash      = r_release_t < (r_push_t + r_repeat);
        w_cycle_inc = (r_cycle != CYCLE_MAX) ? r_cycle + 1'b1 : r_cycle;
        w_rapid_inc = (r_rapid_cnt != RAPID_MAX) ? r_rapid_cnt + 1'b1 : r_rapid_cnt;
        // count after the saturating increment, minus one
        w_n1        = (r_cycle != CYCLE_MAX) ? r_cycle : CYCLE_MAX - 1'b1;
        w_rep_prod  = r_repeat * {{(TIME_W-CYCLE_W){1'b0}}, r_cycle};
        w_step_prod = r_step * {{(TIME_W-CYCLE_W){1'b0}}, w_n1};
        w_target    = r_local ? r_hold_t + r_repeat : r_push_t + w_rep_prod[TIME_W-1:0];
        w_fire      = !((r_in_now + r_offset) < w_target);
        w_lim       = r_floor + w_step_prod[TIME_W-1:0];
        // acceleration: full step until the floor is reached, then clamp
        if (r_repeat >= w_lim) begin
            w_inc = r_local ? r_step : w_step_prod[TIME_W-1:0];
        end else begin
            w_inc = r_repeat - r_floor - (r_local ? r_offset : '0);
        end

        n_pressed    = r_pressed;
        n_push_t     = r_push_t;
        n_release_t  = r_release_t;
        n_hold_t     = r_hold_t;
        n_offset     = r_offset;
        n_cycle      = r_cycle;
        n_rapid_cnt  = r_rapid_cnt;
        n_last_state = r_last_state;
        n_last_rapid = r_last_rapid;

        if (r_enable) begin
            n_last_rapid = 1'b0;
            if (r_in_now < (w_base + r_debounce)) begin
                // inside the debounce window
                n_last_state = r_pressed ? ST_DELAY : ST_IDLE;
            end else if (!r_pressed && !w_active) begin
                n_last_state = ST_IDLE;
            end else if (!r_pressed) begin
                // new push
                n_pressed    = 1'b1;
                n_cycle      = w_cycle_inc;
                n_push_t     = r_in_now;
                n_last_state = ST_PUSH;
                if (w_mash && (r_in_now < (r_release_t + r_repeat))) begin
                    n_rapid_cnt  = w_rapid_inc;
                    n_last_rapid = 1'b1;
                end else begin
                    n_rapid_cnt = '0;
                end
            end else if (!w_active) begin
                // release
                n_pressed    = 1'b0;
                n_cycle      = '0;
                n_release_t  = r_in_now;
                n_last_state = ST_RELEASE;
                n_offset     = '0;
            end else if (w_fire) begin
                // repeat while held
                n_hold_t     = r_in_now;
                n_cycle      = w_cycle_inc;
                n_last_state = ST_HOLD;
                if (r_accel_en) begin
                    n_offset = r_offset + w_inc;
                end
            end else begin
                n_last_state = ST_DELAY;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_invert   <= 1'b0;
            r_local    <= 1'b0;
            r_accel_en <= 1'b0;
            r_debounce <= DEBOUNCE_RESET;
            r_repeat   <= '0;
            r_step     <= '0;
            r_floor    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:      r_enable   <= i_cfg_data[0];
                CFG_INVERT:      r_invert   <= i_cfg_data[0];
                CFG_LOCAL:       r_local    <= i_cfg_data[0];
                CFG_ACCEL_EN:    r_accel_en <= i_cfg_data[0];
                CFG_DEBOUNCE:    r_debounce <= i_cfg_data;
                CFG_REPEAT:      r_repeat   <= i_cfg_data;
                CFG_ACCEL_STEP:  r_step     <= i_cfg_data;
                CFG_ACCEL_FLOOR: r_floor    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // button state, updated once per evaluated poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= 1'b0;
            r_push_t     <= '0;
            r_release_t  <= '0;
            r_hold_t     <= '0;
            r_offset     <= '0;
            r_cycle      <= '0;
            r_rapid_cnt  <= '0;
            r_last_state <= ST_IDLE;
            r_last_rapid <= 1'b0;
        end else if (advance) begin
            r_pressed    <= n_pressed;
            r_push_t     <= n_push_t;
            r_release_t  <= n_release_t;
            r_hold_t     <= n_hold_t;
            r_offset     <= n_offset;
            r_cycle      <= n_cycle;
            r_rapid_cnt  <= n_rapid_cnt;
            r_last_state <= n_last_state;
            r_last_rapid <= n_last_rapid;
        end
    end

    // input and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers need no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_now   <= s_axis_tdata[TIME_W-1:0];
            r_in_level <= s_axis_tdata[TIME_W];
        end
        if (advance) begin
            r_out_state     <= n_last_state;
            r_out_rapid     <= n_last_rapid;
            r_out_rapid_cnt <= n_rapid_cnt;
            r_out_cycle     <= n_cycle;
        end
    end

endmodule

[dv/button_poll_checker.sv]
// result checker for the debounced button block: predicts one report per poll
// and compares it field by field with what comes out of the block
// depends on bdr_pkg
module button_poll_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_poll_valid,
    input  logic                            i_poll_ready,
    input  logic [bdr_pkg::IN_TDATA_W-1:0]  i_poll_data,
    input  logic                            i_report_valid,
    input  logic                            i_report_ready,
    input  logic [bdr_pkg::OUT_TDATA_W-1:0] i_report_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bdr_pkg::TIME_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bdr_pkg::*;

    typedef struct {
        t_state_code        code;
        logic               rapid;
        logic [RAPID_W-1:0] rapid_cnt;
        logic [CYCLE_W-1:0] press_cnt;
    } button_report_t;

    // register copy
    logic              cfg_enable, cfg_invert, cfg_local, cfg_accel;
    logic [TIME_W-1:0] cfg_debounce, cfg_repeat, cfg_step, cfg_floor;

    // button state copy
    logic               btn_down;
    logic [TIME_W-1:0]  push_ts, release_ts, hold_ts, accel_ofs;
    logic [CYCLE_W-1:0] press_cnt;
    logic [RAPID_W-1:0] rapid_cnt;
    t_state_code        last_code;
    logic               last_rapid;

    button_report_t expected_reports[$];
    button_report_t want, got;
    int             fails;

    function automatic button_report_t predict_poll(input logic [TIME_W-1:0] now,
                                                    input logic pin);
        logic [TIME_W-1:0]  base, gate, target, ahead, n1, limit;
        logic [CYCLE_W-1:0] n1_short;
        logic               active, mash;
        button_report_t     rep;
        if (cfg_enable) begin
            base       = (push_ts > release_ts) ? push_ts : release_ts;
            gate       = base + cfg_debounce;
            active     = pin ^ cfg_invert;
            last_rapid = 1'b0;
            if (now < gate) begin
                last_code = btn_down ? ST_DELAY : ST_IDLE;
            end else if (!btn_down && !active) begin
                last_code = ST_IDLE;
            end else if (!btn_down) begin
                gate = push_ts + cfg_repeat;
                mash = release_ts < gate;
                gate = release_ts + cfg_repeat;
                btn_down  = 1'b1;
                if (press_cnt != CYCLE_MAX) press_cnt = press_cnt + 1'b1;
                push_ts   = now;
                last_code = ST_PUSH;
                if (mash && now < gate) begin
                    if (rapid_cnt != RAPID_MAX) rapid_cnt = rapid_cnt + 1'b1;
                    last_rapid = 1'b1;
                end else begin
                    rapid_cnt = '0;
                end
            end else if (!active) begin
                btn_down   = 1'b0;
                press_cnt  = '0;
                release_ts = now;
                last_code  = ST_RELEASE;
                accel_ofs  = '0;
            end else begin
                target = cfg_local ? hold_ts + cfg_repeat
                                   : push_ts + cfg_repeat
                                     * {{(TIME_W-CYCLE_W){1'b0}}, press_cnt};
                ahead  = now + accel_ofs;
                if (ahead >= target) begin
                    hold_ts = now;
                    if (press_cnt != CYCLE_MAX) press_cnt = press_cnt + 1'b1;
                    last_code = ST_HOLD;
                    if (cfg_accel) begin
                        // shorten the interval, clamped by the floor
                        n1_short = press_cnt - 1'b1;
                        n1       = {{(TIME_W-CYCLE_W){1'b0}}, n1_short};
                        limit    = cfg_floor + cfg_step * n1;
                        if (cfg_repeat >= limit)
                            accel_ofs = accel_ofs + cfg_step * (cfg_local ? 32'd1 : n1);
                        else
                            accel_ofs = accel_ofs + cfg_repeat - cfg_floor
                                        - (cfg_local ? accel_ofs : 32'd0);
                    end
                end else begin
                    last_code = ST_DELAY;
                end
            end
        end
        rep.code      = last_code;
        rep.rapid     = last_rapid;
        rep.rapid_cnt = rapid_cnt;
        rep.press_cnt = press_cnt;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_enable   = 1'b0;
            cfg_invert   = 1'b0;
            cfg_local    = 1'b0;
            cfg_accel    = 1'b0;
            cfg_debounce = DEBOUNCE_RESET;
            cfg_repeat   = '0;
            cfg_step     = '0;
            cfg_floor    = '0;
            btn_down     = 1'b0;
            push_ts      = '0;
            release_ts   = '0;
            hold_ts      = '0;
            accel_ofs    = '0;
            press_cnt    = '0;
            rapid_cnt    = '0;
            last_code    = ST_IDLE;
            last_rapid   = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLE:      cfg_enable   = i_cfg_data[0];
                    CFG_INVERT:      cfg_invert   = i_cfg_data[0];
                    CFG_LOCAL:       cfg_local    = i_cfg_data[0];
                    CFG_ACCEL_EN:    cfg_accel    = i_cfg_data[0];
                    CFG_DEBOUNCE:    cfg_debounce = i_cfg_data;
                    CFG_REPEAT:      cfg_repeat   = i_cfg_data;
                    CFG_ACCEL_STEP:  cfg_step     = i_cfg_data;
                    CFG_ACCEL_FLOOR: cfg_floor    = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before queuing so a report can never match its own poll
            if (i_report_valid && i_report_ready) begin
                got.code      = t_state_code'(i_report_data[2:0]);
                got.rapid     = i_report_data[3];
                got.rapid_cnt = i_report_data[11:4];
                got.press_cnt = i_report_data[27:12];
                if (expected_reports.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected report: code %0d rapid %0b presses %0d repeats %0d",
                                 got.code, got.rapid, got.rapid_cnt, got.press_cnt);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.code !== want.code || got.rapid !== want.rapid ||
                        got.rapid_cnt !== want.rapid_cnt ||
                        got.press_cnt !== want.press_cnt) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("report mismatch: expected code %0d rapid %0b %s %0d %s %0d",
                                     want.code, want.rapid, "presses", want.rapid_cnt,
                                     "repeats", want.press_cnt);
                            $display("                 actual   code %0d rapid %0b %s %0d %s %0d",
                                     got.code, got.rapid, "presses", got.rapid_cnt,
                                     "repeats", got.press_cnt);
                        end
                    end
                end
            end
            if (i_poll_valid && i_poll_ready)
                expected_reports.push_back(predict_poll(i_poll_data[TIME_W-1:0],
                                                        i_poll_data[TIME_W]));
        end
        o_fail_count <= fails;
        o_pending    <= expected_reports.size();
    end

endmodule

[dv/button_debounce_repeat_fsm_test.sv]
// testbench top for the debounced button with auto-repeat: drives polls and
// register writes, randomizes both handshakes and gives the verdict
// depends on bdr_pkg, button_poll_checker and the block itself
module button_debounce_repeat_fsm_test;
    import bdr_pkg::*;

    // generous bound, many times a correct run with every stall and idle gap
    localparam int unsigned RUN_LIMIT = 40000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [TIME_W-1:0]      i_cfg_data;

    int                     fail_count;
    int                     pending;
    int unsigned            cycle_cnt;
    int                     stall_left;

    // stimulus state: running millisecond clock and the intended button level
    logic [TIME_W-1:0]      clock_ms;
    logic                   active_lvl;
    logic                   cur_invert;
    int                     run_left;
    bit                     idle_en;
    bit                     hold_armed;
    bit                     hold_done;

    button_debounce_repeat_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    button_poll_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_poll_valid   (s_axis_tvalid),
        .i_poll_ready   (s_axis_tready),
        .i_poll_data    (s_axis_tdata),
        .i_report_valid (m_axis_tvalid),
        .i_report_ready (m_axis_tready),
        .i_report_data  (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off while the
    // sender keeps offering, so the pipeline fills and input ready drops
    initial begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                stall_left = 64;
                while (stall_left > 0) begin
                    @(posedge i_clk);
                    stall_left--;
                end
            end else if (idle_en) begin
                m_axis_tready <= ($urandom_range(99) >= 26);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one poll item; random idle cycles before it, then hold until taken
    task automatic send_poll(input logic [TIME_W-1:0] now_ms, input logic pin_level);
        while (idle_en && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        // upper pad bits stay zero
        s_axis_tdata  <= {7'b0, pin_level, now_ms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait for every report, then let the pipeline drain
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [TIME_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // full register set, written only once the block is idle
    task automatic write_settings(input logic en, input logic inv, input logic loc,
                                  input logic acc, input logic [TIME_W-1:0] deb,
                                  input logic [TIME_W-1:0] rep,
                                  input logic [TIME_W-1:0] stp,
                                  input logic [TIME_W-1:0] flr);
        wait_drained();
        write_register(CFG_ENABLE, {31'b0, en});
        write_register(CFG_INVERT, {31'b0, inv});
        write_register(CFG_LOCAL, {31'b0, loc});
        write_register(CFG_ACCEL_EN, {31'b0, acc});
        write_register(CFG_DEBOUNCE, deb);
        write_register(CFG_REPEAT, rep);
        write_register(CFG_ACCEL_STEP, stp);
        write_register(CFG_ACCEL_FLOOR, flr);
        i_cfg_valid <= 1'b0;
        cur_invert = inv;
    endtask

    // press/release runs with bounces, long gaps and a little pin noise
    task automatic run_presses(input int n_items, input int step_max);
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                active_lvl = ~active_lvl;
                // short runs model contact bounce
                run_left = ($urandom_range(3) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(3, 25);
            end
            run_left--;
            clock_ms = clock_ms + $urandom_range(1, step_max);
            if ($urandom_range(29) == 0) clock_ms = clock_ms + $urandom_range(0, 3000);
            if ($urandom_range(19) == 0)
                send_poll(clock_ms, 1'($urandom_range(1)));
            else
                send_poll(clock_ms, active_lvl ^ cur_invert);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_ENABLE;
        i_cfg_data    <= '0;
        idle_en       <= 1'b1;
        hold_armed    <= 1'b0;
        clock_ms   = '0;
        active_lvl = 1'b0;
        cur_invert = 1'b0;
        run_left   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: reset state is echoed, time extremes
        send_poll(32'h0000_0000, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b0);

        // directed press: debounce, push with rapid, hold, release, rapid again
        write_settings(1'b1, 1'b0, 1'b0, 1'b0, 32'd10, 32'd100, 32'd0, 32'd0);
        send_poll(32'd1, 1'b1);
        send_poll(32'd20, 1'b1);
        send_poll(32'd25, 1'b1);
        send_poll(32'd100, 1'b1);
        send_poll(32'd120, 1'b1);
        send_poll(32'd220, 1'b1);
        send_poll(32'd230, 1'b0);
        send_poll(32'd235, 1'b1);
        send_poll(32'd250, 1'b1);
        send_poll(32'd260, 1'b0);
        send_poll(32'd300, 1'b1);
        send_poll(32'd301, 1'b1);

        // active-low pin, hold-relative repeats with acceleration
        write_settings(1'b1, 1'b1, 1'b1, 1'b1, 32'd0, 32'd30, 32'd5, 32'd10);
        send_poll(32'd400, 1'b0);
        send_poll(32'd410, 1'b0);
        send_poll(32'd420, 1'b0);
        send_poll(32'd430, 1'b0);
        send_poll(32'd440, 1'b1);
        send_poll(32'd450, 1'b1);

        clock_ms = 32'd500;

        // random press sequences under several settings
        write_settings(1'b1, 1'b0, 1'b0, 1'b0, 32'd10, 32'd60, 32'd0, 32'd0);
        run_presses(50, 8);

        // stretch with no idling, and the long receiver hold-off
        write_settings(1'b1, 1'b1, 1'b1, 1'b0, 32'd5, 32'd40, 32'd0, 32'd0);
        idle_en    <= 1'b0;
        hold_armed <= 1'b1;
        run_presses(50, 6);

        write_settings(1'b1, 1'b0, 1'b0, 1'b1, 32'd8, 32'd80, 32'd10, 32'd20);
        idle_en <= 1'b1;
        run_presses(50, 10);

        write_settings(1'b1, 1'b1, 1'b1, 1'b1, 32'd3, 32'd50, 32'd7, 32'd15);
        run_presses(50, 6);

        // disabled: state must be frozen
        write_settings(1'b0, 1'b1, 1'b0, 1'b1, 32'd20, 32'd90, 32'd3, 32'd4);
        run_presses(20, 10);

        // zero debounce and repeat, step and floor at their maximum
        write_settings(1'b1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_presses(40, 4);

        // debounce and repeat at their maximum, sums wrap
        write_settings(1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);
        run_presses(30, 20);

        // quick taps inside a wide rapid window, back to back
        write_settings(1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd1000, 32'd0, 32'd0);
        idle_en <= 1'b0;
        for (int i = 0; i < 30; i++) begin
            clock_ms = clock_ms + 1'b1;
            send_poll(clock_ms, (i % 2) == 0);
        end

        // zero interval: one hold per poll
        write_settings(1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 30; i++) begin
            clock_ms = clock_ms + 1'b1;
            send_poll(clock_ms, 1'b1);
        end
        clock_ms = clock_ms + 1'b1;
        send_poll(clock_ms, 1'b0);

        // millisecond clock wraps through zero mid-phase
        write_settings(1'b1, 1'b0, 1'b0, 1'b1, 32'd6, 32'd45, 32'd4, 32'd9);
        idle_en <= 1'b1;
        clock_ms = 32'hFFFF_FF00;
        run_presses(60, 10);

        write_settings(1'b1, 1'b1, 1'b0, 1'b0, 32'd12, 32'd70, 32'd0, 32'd0);
        run_presses(40, 8);

        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[button_debounce_repeat_fsm.f]
src/bdr_pkg.sv
src/button_debounce_repeat_fsm.sv
dv/button_poll_checker.sv
dv/button_debounce_repeat_fsm_test.sv
